// ===== sv/mae_pkg.sv =====
// shared types and constants for the mips alu execute block
// decode masks, opcode and function codes, alu result struct
// no dependencies
`default_nettype none

package mae_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned REG_AW    = 5;
    localparam int unsigned REG_DEPTH = 32;

    // r-type group after masking with the opcode, shamt and funct fields
    localparam logic [XLEN-1:0] MASK_RTYPE = 32'hfc00_07ff;
    localparam logic [XLEN-1:0] ENC_ADD    = 32'h0000_0020;
    localparam logic [XLEN-1:0] ENC_SUB    = 32'h0000_0022;
    localparam logic [XLEN-1:0] ENC_MUL    = 32'h7000_0002;
    localparam logic [XLEN-1:0] ENC_AND    = 32'h0000_0024;
    localparam logic [XLEN-1:0] ENC_OR     = 32'h0000_0025;
    localparam logic [XLEN-1:0] ENC_XOR    = 32'h0000_0026;
    localparam logic [XLEN-1:0] ENC_SLLV   = 32'h0000_0004;
    localparam logic [XLEN-1:0] ENC_SRLV   = 32'h0000_0006;
    localparam logic [XLEN-1:0] ENC_SLT    = 32'h0000_002a;

    // primary opcodes
    localparam logic [5:0] OPC_SPECIAL = 6'd0;
    localparam logic [5:0] OPC_ADDI    = 6'd8;
    localparam logic [5:0] OPC_SLTI    = 6'd10;
    localparam logic [5:0] OPC_ANDI    = 6'd12;
    localparam logic [5:0] OPC_ORI     = 6'd13;
    localparam logic [5:0] OPC_XORI    = 6'd14;
    localparam logic [5:0] OPC_LUI     = 6'd15;

    // function codes of the immediate shifts
    localparam logic [5:0] FUNCT_SLL = 6'd0;
    localparam logic [5:0] FUNCT_SRL = 6'd2;

    localparam int unsigned LUI_SHIFT = 16;
    localparam logic [XLEN-1:0] PC_STEP = 32'd4;

    typedef struct packed {
        logic              recognized;
        logic [REG_AW-1:0] dest;
        logic [XLEN-1:0]   value;
    } t_alu_res;

endpackage

`default_nettype wire

// ===== sv/mae_if.sv =====
// valid/ready stream interfaces for instruction words and alu results
// depends on mae_pkg
`default_nettype none

interface mae_instr_if
    import mae_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [XLEN-1:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface mae_result_if
    import mae_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              recognized;
    logic [REG_AW-1:0] dest_index;
    logic [XLEN-1:0]   dest_value;
    logic [XLEN-1:0]   next_pc;

    modport source (output valid, output recognized, output dest_index,
                    output dest_value, output next_pc, input ready);
    modport sink   (input valid, input recognized, input dest_index,
                    input dest_value, input next_pc, output ready);
endinterface

`default_nettype wire

// ===== sv/mae_regfile.sv =====
// 32 x 32 register file, synchronous memory with two read ports
// registered read data, write forwarding and per-entry valid bits
// depends on mae_pkg
`default_nettype none

module mae_regfile
    import mae_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [REG_AW-1:0] i_rs_addr,
    input  wire logic [REG_AW-1:0] i_rt_addr,
    output logic      [XLEN-1:0]   o_rs_data,
    output logic      [XLEN-1:0]   o_rt_data,
    input  wire logic              i_wr_en,
    input  wire logic [REG_AW-1:0] i_wr_addr,
    input  wire logic [XLEN-1:0]   i_wr_data
);

    logic [XLEN-1:0]      r_mem [REG_DEPTH];
    logic [REG_DEPTH-1:0] r_valid;

    logic [XLEN-1:0] r_rs_raw;
    logic [XLEN-1:0] r_rt_raw;
    logic            r_rs_ok;
    logic            r_rt_ok;
    logic            r_rs_fwd;
    logic            r_rt_fwd;
    logic [XLEN-1:0] r_fwd_data;

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // memory read ports, data registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rs_raw <= r_mem[i_rs_addr];
            r_rt_raw <= r_mem[i_rt_addr];
        end
    end

    // valid bits: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // read qualifiers and same-edge write forwarding
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rs_ok    <= r_valid[i_rs_addr] && (i_rs_addr != '0);
            r_rt_ok    <= r_valid[i_rt_addr] && (i_rt_addr != '0);
            r_rs_fwd   <= i_wr_en && (i_wr_addr == i_rs_addr) && (i_rs_addr != '0);
            r_rt_fwd   <= i_wr_en && (i_wr_addr == i_rt_addr) && (i_rt_addr != '0);
            r_fwd_data <= i_wr_data;
        end
    end

    // read data select
    always_comb begin
        if (r_rs_fwd) begin
            o_rs_data = r_fwd_data;
        end else if (r_rs_ok) begin
            o_rs_data = r_rs_raw;
        end else begin
            o_rs_data = '0;
        end
        if (r_rt_fwd) begin
            o_rt_data = r_fwd_data;
        end else if (r_rt_ok) begin
            o_rt_data = r_rt_raw;
        end else begin
            o_rt_data = '0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mae_alu.sv =====
// instruction decode and alu for the r-type and immediate subset
// combinational, one 32 x 32 multiply in the path
// depends on mae_pkg
`default_nettype none

module mae_alu
    import mae_pkg::*;
(
    input  wire logic [XLEN-1:0] i_instruction,
    input  wire logic [XLEN-1:0] i_a,
    input  wire logic [XLEN-1:0] i_b,
    output t_alu_res             o_res
);

    logic [5:0]        opc;
    logic [REG_AW-1:0] rs;
    logic [REG_AW-1:0] rt;
    logic [REG_AW-1:0] rd;
    logic [4:0]        shamt;
    logic [5:0]        funct;
    logic [15:0]       imm;
    logic [XLEN-1:0]   zimm;
    logic [XLEN-1:0]   simm;
    logic [XLEN-1:0]   masked;
    logic [XLEN-1:0]   product;
    logic              lt_reg;
    logic              lt_imm;

    // field extraction
    assign opc    = i_instruction[31:26];
    assign rs     = i_instruction[25:21];
    assign rt     = i_instruction[20:16];
    assign rd     = i_instruction[15:11];
    assign shamt  = i_instruction[10:6];
    assign funct  = i_instruction[5:0];
    assign imm    = i_instruction[15:0];
    assign zimm   = {16'd0, imm};
    assign simm   = {{16{imm[15]}}, imm};
    assign masked = i_instruction & MASK_RTYPE;

    // shared datapath pieces
    assign product = i_a * i_b;
    assign lt_reg  = $signed(i_a) < $signed(i_b);
    assign lt_imm  = $signed(i_a) < $signed(simm);

    // decode and select
    always_comb begin
        o_res.recognized = 1'b1;
        o_res.dest       = rd;
        o_res.value      = '0;
        case (masked)
            ENC_ADD:  o_res.value = i_a + i_b;
            ENC_SUB:  o_res.value = i_a - i_b;
            ENC_MUL:  o_res.value = product;
            ENC_AND:  o_res.value = i_a & i_b;
            ENC_OR:   o_res.value = i_a | i_b;
            ENC_XOR:  o_res.value = i_a ^ i_b;
            ENC_SLLV: o_res.value = i_b << i_a[4:0];
            ENC_SRLV: o_res.value = i_b >> i_a[4:0];
            ENC_SLT:  o_res.value = {31'd0, lt_reg};
            default: begin
                if (opc == OPC_SPECIAL && rs == '0 && funct == FUNCT_SLL) begin
                    o_res.value = i_b << shamt;
                end else if (opc == OPC_SPECIAL && rs == '0 && funct == FUNCT_SRL) begin
                    o_res.value = i_b >> shamt;
                end else if (opc == OPC_ADDI) begin
                    o_res.dest  = rt;
                    o_res.value = i_a + simm;
                end else if (opc == OPC_SLTI) begin
                    o_res.dest  = rt;
                    o_res.value = {31'd0, lt_imm};
                end else if (opc == OPC_ANDI) begin
                    o_res.dest  = rt;
                    o_res.value = i_a & zimm;
                end else if (opc == OPC_ORI) begin
                    o_res.dest  = rt;
                    o_res.value = i_a | zimm;
                end else if (opc == OPC_XORI) begin
                    o_res.dest  = rt;
                    o_res.value = i_a ^ zimm;
                end else if (opc == OPC_LUI && rs == '0) begin
                    o_res.dest  = rt;
                    o_res.value = zimm << LUI_SHIFT;
                end else begin
                    o_res.recognized = 1'b0;
                    o_res.dest       = '0;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/mips_alu_instruction_execute.sv =====
// Executes one MIPS ALU instruction per cycle at a sustained rate of one
// transfer per clock while the result side is ready; back-pressure stalls it.
// The first stage is the register-file read (synchronous memory, registered
// data, writes from the previous instruction forwarded), the
// second decodes, executes, writes back and loads the output register, which
// lets the next instruction enter while a result waits to be taken. Every
// instruction yields one result; unrecognized words report zeros and leave
// the registers unchanged. The program counter starts at zero after reset.
// depends on mae_pkg, mae_if, mae_regfile and mae_alu
`default_nettype none

module mips_alu_instruction_execute
    import mae_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mae_instr_if.sink    i_instr,
    mae_result_if.source o_result
);

    logic            r_s1_vld;
    logic [XLEN-1:0] r_s1_instr;
    logic            r_out_vld;
    logic [XLEN-1:0] r_pc;
    logic [XLEN-1:0] n_pc;
    t_alu_res        r_out_res;
    logic [XLEN-1:0] r_out_pc;

    logic            accept;
    logic            s1_move;
    logic [XLEN-1:0] rs_data;
    logic [XLEN-1:0] rt_data;
    t_alu_res        alu_res;
    logic            wr_en;

    // handshake control
    assign s1_move       = r_s1_vld && (!r_out_vld || o_result.ready);
    assign i_instr.ready = !r_s1_vld || s1_move;
    assign accept        = i_instr.valid && i_instr.ready;
    assign wr_en         = s1_move && alu_res.recognized && (alu_res.dest != '0);
    assign n_pc          = r_pc + PC_STEP;

    // register file
    mae_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rs_addr (i_instr.instruction[25:21]),
        .i_rt_addr (i_instr.instruction[20:16]),
        .o_rs_data (rs_data),
        .o_rt_data (rt_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (alu_res.dest),
        .i_wr_data (alu_res.value)
    );

    // decode and execute
    mae_alu u_alu (
        .i_instruction (r_s1_instr),
        .i_a           (rs_data),
        .i_b           (rt_data),
        .o_res         (alu_res)
    );

    // read stage holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_instr <= i_instr.instruction;
        end
    end

    // output register and program counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_pc      <= '0;
        end else begin
            if (s1_move) begin
                r_out_vld <= 1'b1;
                r_pc      <= n_pc;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_res <= alu_res;
            r_out_pc  <= n_pc;
        end
    end

    assign o_result.valid      = r_out_vld;
    assign o_result.recognized = r_out_res.recognized;
    assign o_result.dest_index = r_out_res.dest;
    assign o_result.dest_value = r_out_res.value;
    assign o_result.next_pc    = r_out_pc;

endmodule

`default_nettype wire

// ===== sim/alu_retire_checker.sv =====
`timescale 1ns / 1ps
// result checker for the mips alu execute block: keeps its own register file
// and program counter, predicts every result and compares it on transfer
// depends on mae_pkg and mae_if
module alu_retire_checker
    import mae_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mae_instr_if      i_instr_mon,
    mae_result_if     i_result_mon,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic              recognized;
        logic [REG_AW-1:0] dest_index;
        logic [XLEN-1:0]   dest_value;
        logic [XLEN-1:0]   next_pc;
    } t_retire;

    logic [XLEN-1:0] gpr [REG_DEPTH];
    logic [XLEN-1:0] pc_model;
    t_retire         retire_q [$];
    int              fail_count = 0;

    // register zero always reads as zero
    function automatic logic [XLEN-1:0] read_gpr(input logic [REG_AW-1:0] idx);
        return (idx == '0) ? '0 : gpr[idx];
    endfunction

    // decode and execute one word, update the model state, return the result
    function automatic t_retire execute_word(input logic [XLEN-1:0] w);
        logic [5:0]        opc;
        logic [5:0]        funct;
        logic [REG_AW-1:0] rs;
        logic [REG_AW-1:0] rt;
        logic [REG_AW-1:0] rd;
        logic [4:0]        shamt;
        logic [15:0]       imm;
        logic [XLEN-1:0]   simm;
        logic [XLEN-1:0]   a;
        logic [XLEN-1:0]   b;
        t_retire           r;

        opc   = w[31:26];
        rs    = w[25:21];
        rt    = w[20:16];
        rd    = w[15:11];
        shamt = w[10:6];
        funct = w[5:0];
        imm   = w[15:0];
        simm  = {{16{imm[15]}}, imm};
        a     = read_gpr(rs);
        b     = read_gpr(rt);
        r     = '0;
        r.recognized = 1'b1;

        case (w & MASK_RTYPE)
            ENC_ADD: begin r.dest_index = rd; r.dest_value = a + b; end
            ENC_SUB: begin r.dest_index = rd; r.dest_value = a - b; end
            ENC_MUL: begin r.dest_index = rd; r.dest_value = a * b; end
            ENC_AND: begin r.dest_index = rd; r.dest_value = a & b; end
            ENC_OR:  begin r.dest_index = rd; r.dest_value = a | b; end
            ENC_XOR: begin r.dest_index = rd; r.dest_value = a ^ b; end
            ENC_SLLV: begin r.dest_index = rd; r.dest_value = b << a[4:0]; end
            ENC_SRLV: begin r.dest_index = rd; r.dest_value = b >> a[4:0]; end
            ENC_SLT: begin
                r.dest_index = rd;
                r.dest_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            end
            default: begin
                if (opc == OPC_SPECIAL && rs == '0 && funct == FUNCT_SLL) begin
                    r.dest_index = rd;
                    r.dest_value = b << shamt;
                end else if (opc == OPC_SPECIAL && rs == '0 && funct == FUNCT_SRL) begin
                    r.dest_index = rd;
                    r.dest_value = b >> shamt;
                end else if (opc == OPC_ADDI) begin
                    r.dest_index = rt;
                    r.dest_value = a + simm;
                end else if (opc == OPC_SLTI) begin
                    r.dest_index = rt;
                    r.dest_value = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
                end else if (opc == OPC_ANDI) begin
                    r.dest_index = rt;
                    r.dest_value = a & XLEN'(imm);
                end else if (opc == OPC_ORI) begin
                    r.dest_index = rt;
                    r.dest_value = a | XLEN'(imm);
                end else if (opc == OPC_XORI) begin
                    r.dest_index = rt;
                    r.dest_value = a ^ XLEN'(imm);
                end else if (opc == OPC_LUI && rs == '0) begin
                    r.dest_index = rt;
                    r.dest_value = XLEN'(imm) << LUI_SHIFT;
                end else begin
                    r.recognized = 1'b0;
                end
            end
        endcase

        // writes to register zero are reported but dropped
        if (r.recognized && r.dest_index != '0) begin
            gpr[r.dest_index] = r.dest_value;
        end
        pc_model  = pc_model + PC_STEP;
        r.next_pc = pc_model;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    // results leave before new words enter, so pop ahead of push
    always @(posedge i_clk) begin : monitor
        t_retire want;

        if (!i_rst_n) begin
            for (int i = 0; i < REG_DEPTH; i++) begin
                gpr[i] = '0;
            end
            pc_model = '0;
            retire_q.delete();
        end else begin
            if (i_result_mon.valid && i_result_mon.ready) begin
                if (retire_q.size() == 0) begin
                    $error("result transfer with no instruction outstanding");
                    fail_count++;
                end else begin
                    want = retire_q.pop_front();
                    check_field("recognized", XLEN'(want.recognized),
                                XLEN'(i_result_mon.recognized));
                    check_field("dest_index", XLEN'(want.dest_index),
                                XLEN'(i_result_mon.dest_index));
                    check_field("dest_value", want.dest_value, i_result_mon.dest_value);
                    check_field("next_pc", want.next_pc, i_result_mon.next_pc);
                end
            end
            if (i_instr_mon.valid && i_instr_mon.ready) begin
                retire_q.push_back(execute_word(i_instr_mon.instruction));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= retire_q.size();
    end

endmodule

// ===== sim/mips_alu_instruction_execute_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the mips alu execute block: clock, reset, instruction
// stimulus, result back-pressure and the final verdict
// depends on mae_pkg, mae_if, the block and alu_retire_checker
module mips_alu_instruction_execute_tb;
    import mae_pkg::*;

    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 10;

    // a load word, outside the implemented set
    localparam logic [5:0] OPC_LW = 6'h23;

    typedef enum int {
        OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SLLV, OP_SRLV, OP_SLT,
        OP_SLL, OP_SRL, OP_ADDI, OP_SLTI, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
        OP_BROKEN, OP_RAW
    } t_gen_kind;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;
    int   cycle_count = 0;
    int   fail_count;
    int   pending;

    mae_instr_if  instr_bus ();
    mae_result_if result_bus ();

    mips_alu_instruction_execute dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_bus),
        .o_result (result_bus)
    );

    alu_retire_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_instr_mon  (instr_bus),
        .i_result_mon (result_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // instruction word builders
    function automatic logic [XLEN-1:0] r_word(input logic [XLEN-1:0] enc,
                                               input logic [4:0] rs, rt, rd);
        return enc | {6'b0, rs, rt, rd, 11'b0};
    endfunction

    function automatic logic [XLEN-1:0] shift_word(input logic [4:0] rs, rt, rd, sh,
                                                   input logic [5:0] funct);
        return {OPC_SPECIAL, rs, rt, rd, sh, funct};
    endfunction

    function automatic logic [XLEN-1:0] i_word(input logic [5:0] opc,
                                               input logic [4:0] rs, rt,
                                               input logic [15:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    // mostly well-formed operations with random registers, some broken or raw words
    function automatic logic [XLEN-1:0] random_word();
        t_gen_kind   kind;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [4:0]  nz;
        logic [15:0] imm;

        kind = t_gen_kind'($urandom_range(OP_ADD, OP_RAW));
        rs   = 5'($urandom_range(31));
        rt   = 5'($urandom_range(31));
        rd   = 5'($urandom_range(31));
        sh   = 5'($urandom_range(31));
        nz   = 5'($urandom_range(1, 31));
        case ($urandom_range(7))
            0: imm = 16'h0000;
            1: imm = 16'hffff;
            2: imm = 16'h8000;
            3: imm = 16'h7fff;
            default: imm = 16'($urandom_range(16'hffff));
        endcase

        case (kind)
            OP_ADD:  return r_word(ENC_ADD, rs, rt, rd);
            OP_SUB:  return r_word(ENC_SUB, rs, rt, rd);
            OP_MUL:  return r_word(ENC_MUL, rs, rt, rd);
            OP_AND:  return r_word(ENC_AND, rs, rt, rd);
            OP_OR:   return r_word(ENC_OR, rs, rt, rd);
            OP_XOR:  return r_word(ENC_XOR, rs, rt, rd);
            OP_SLLV: return r_word(ENC_SLLV, rs, rt, rd);
            OP_SRLV: return r_word(ENC_SRLV, rs, rt, rd);
            OP_SLT:  return r_word(ENC_SLT, rs, rt, rd);
            OP_SLL:  return shift_word(5'd0, rt, rd, sh, FUNCT_SLL);
            OP_SRL:  return shift_word(5'd0, rt, rd, sh, FUNCT_SRL);
            OP_ADDI: return i_word(OPC_ADDI, rs, rt, imm);
            OP_SLTI: return i_word(OPC_SLTI, rs, rt, imm);
            OP_ANDI: return i_word(OPC_ANDI, rs, rt, imm);
            OP_ORI:  return i_word(OPC_ORI, rs, rt, imm);
            OP_XORI: return i_word(OPC_XORI, rs, rt, imm);
            OP_LUI:  return i_word(OPC_LUI, 5'd0, rt, imm);
            OP_BROKEN: begin
                case ($urandom_range(2))
                    0: return r_word(ENC_SUB, rs, rt, rd) | {21'b0, nz, 6'b0};
                    1: return shift_word(nz, rt, rd, sh, FUNCT_SRL);
                    default: return i_word(OPC_LUI, nz, rt, imm);
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // one instruction transfer, with random idle cycles ahead of it
    task automatic send_word(input logic [XLEN-1:0] word);
        while ($urandom_range(99) < src_idle_pct) begin
            instr_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        instr_bus.valid       <= 1'b1;
        instr_bus.instruction <= word;
        @(posedge i_clk);
        while (!instr_bus.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int count, input int src_pct, input int sink_pct,
                             input bit hold_off);
        src_idle_pct   <= src_pct;
        sink_stall_pct <= sink_pct;
        if (hold_off) begin
            hold_toggle <= ~hold_toggle;
        end
        repeat (count) begin
            send_word(random_word());
        end
    endtask

    initial begin : stimulus
        logic [XLEN-1:0] directed_words [$];

        instr_bus.valid       = 1'b0;
        instr_bus.instruction = '0;
        result_bus.ready      = 1'b0;
        i_rst_n               = 1'b0;
        src_idle_pct          = 0;
        sink_stall_pct        = 0;

        directed_words = '{
            // build extreme operands
            i_word(OPC_LUI, 5'd0, 5'd1, 16'hffff),
            i_word(OPC_ORI, 5'd1, 5'd1, 16'hffff),
            i_word(OPC_LUI, 5'd0, 5'd2, 16'h8000),
            i_word(OPC_ADDI, 5'd0, 5'd3, 16'h7fff),
            i_word(OPC_ADDI, 5'd0, 5'd4, 16'h8000),
            // every register operation
            r_word(ENC_ADD, 5'd1, 5'd2, 5'd5),
            r_word(ENC_SUB, 5'd0, 5'd1, 5'd6),
            r_word(ENC_MUL, 5'd1, 5'd2, 5'd7),
            r_word(ENC_AND, 5'd1, 5'd4, 5'd8),
            r_word(ENC_OR, 5'd2, 5'd3, 5'd9),
            r_word(ENC_XOR, 5'd1, 5'd3, 5'd10),
            r_word(ENC_SLLV, 5'd1, 5'd3, 5'd11),
            r_word(ENC_SRLV, 5'd3, 5'd1, 5'd12),
            r_word(ENC_SLT, 5'd2, 5'd3, 5'd13),
            r_word(ENC_SLT, 5'd3, 5'd2, 5'd14),
            shift_word(5'd0, 5'd1, 5'd15, 5'd31, FUNCT_SLL),
            shift_word(5'd0, 5'd1, 5'd16, 5'd31, FUNCT_SRL),
            i_word(OPC_SLTI, 5'd2, 5'd17, 16'hffff),
            i_word(OPC_ANDI, 5'd1, 5'd18, 16'hffff),
            i_word(OPC_XORI, 5'd1, 5'd19, 16'hffff),
            // write to register zero, then read it back
            r_word(ENC_ADD, 5'd1, 5'd1, 5'd0),
            r_word(ENC_ADD, 5'd0, 5'd0, 5'd20),
            // unrecognized words: shamt on an r-type, rs on a shift and lui, a load
            r_word(ENC_ADD, 5'd1, 5'd2, 5'd21) | {21'b0, 5'd1, 6'b0},
            shift_word(5'd1, 5'd1, 5'd22, 5'd4, FUNCT_SLL),
            i_word(OPC_LUI, 5'd1, 5'd23, 16'h1234),
            i_word(OPC_LW, 5'd1, 5'd2, 16'h0000),
            32'hffff_ffff
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_words[i]) begin
            send_word(directed_words[i]);
        end

        // steady flow, sender gaps, receiver stalls with a long hold-off, both
        run_phase(RANDOM_ITEMS / 4, 0, 0, 1'b0);
        run_phase(RANDOM_ITEMS / 4, 68, 0, 1'b0);
        run_phase(RANDOM_ITEMS / 4, 0, 68, 1'b1);
        run_phase(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4), 34, 34, 1'b0);
        instr_bus.valid <= 1'b0;

        // wait for every outstanding result, then a short drain
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
